@@ src/qmrb_pkg.sv @@
// Shared types and constants for the quintic move/rest/back profile unit.
package qmrb_pkg;

    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int VEL_W      = 48;
    localparam int PHASE_W    = 3;
    localparam int RECIP_W    = 33;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 33;
    localparam int INNER_W    = 36;
    localparam int VMAG_W     = 47;

    localparam logic [RECIP_W-1:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [63:0]        HALF_Q32   = 64'h0000_0000_8000_0000;
    localparam logic [INNER_W-1:0] INNER_BASE = 36'ha_0000_0000;
    localparam logic [VMAG_W-1:0]  VEL_CAP    = 47'h7fff_ffff_ffff;
    localparam logic [POS_W-1:0]   POS_MAX    = 32'h7fff_ffff;
    localparam logic [POS_W-1:0]   NEG_MAX    = 32'h8000_0000;

    // reset values of the configuration registers
    localparam logic [31:0]        RST_AMP   = 32'd0;
    localparam logic [31:0]        RST_START = 32'd0;
    localparam logic [31:0]        RST_MOVE  = 32'd1;
    localparam logic [31:0]        RST_REST  = 32'd0;
    localparam logic [31:0]        RST_BACK  = 32'd1;
    localparam logic [RECIP_W-1:0] RST_RECIP = ONE_Q32;

    typedef enum logic [PHASE_W-1:0] {
        PH_BEFORE = 3'd0,
        PH_RISE   = 3'd1,
        PH_HOLD   = 3'd2,
        PH_FALL   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE  = 4'd0,
        CFG_START_TIME = 4'd1,
        CFG_MOVE_TIME  = 4'd2,
        CFG_REST_TIME  = 4'd3,
        CFG_BACK_TIME  = 4'd4,
        CFG_MOVE_RECIP = 4'd5,
        CFG_BACK_RECIP = 4'd6,
        CFG_MODE       = 4'd7
    } t_cfg_idx;

endpackage

@@ src/qmrb_if.sv @@
// Valid/ready channel interfaces: time input, profile output, register writes.
interface qmrb_in_if import qmrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, output time_now, input ready);
    modport sink   (input valid, input time_now, output ready);
endinterface

interface qmrb_out_if import qmrb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [VEL_W-1:0]    velocity;
    logic [PHASE_W-1:0]  phase;

    modport source (output valid, output position, output velocity, output phase,
                    input ready);
    modport sink   (input valid, input position, input velocity, input phase,
                    output ready);
endinterface

interface qmrb_cfg_if import qmrb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/quintic_move_rest_back_profile_unit.sv @@
// Minimum-jerk quintic move/rest/back profile evaluator, ten-stage pipeline.
// Each result passes through the ten register stages, stage 1 to the output
//   register, before it is presented on o_out.
// Throughput: one time sample per cycle while o_out is not stalled; the multipliers
//   are spread over the stages, with a register after each stage.
// Back-pressure stalls every stage at once; i_in.ready drops only while a
//   result sits on o_out unaccepted.
// Reset (i_rst_n low, synchronous) clears all valid bits and loads the register
//   defaults: amplitude 0, start 0, move/back time 1, recips 2^32, mode 0.
module quintic_move_rest_back_profile_unit import qmrb_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qmrb_in_if.sink             i_in,
    qmrb_out_if.source          o_out,
    qmrb_cfg_if.sink            i_cfg
);

    // effective time width: the time port is 32 bits, masked to TIME_BITS
    localparam int TW  = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int TW1 = TW + 1;
    localparam int BW  = TW + 2;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [31:0]        r_amp, r_start, r_move, r_rest, r_back;
    logic [RECIP_W-1:0] r_mrecip, r_brecip;
    logic               r_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp    <= RST_AMP;
            r_start  <= RST_START;
            r_move   <= RST_MOVE;
            r_rest   <= RST_REST;
            r_back   <= RST_BACK;
            r_mrecip <= RST_RECIP;
            r_brecip <= RST_RECIP;
            r_mode   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_AMPLITUDE:  r_amp    <= i_cfg.data[31:0];
                CFG_START_TIME: r_start  <= i_cfg.data[31:0];
                CFG_MOVE_TIME:  r_move   <= i_cfg.data[31:0];
                CFG_REST_TIME:  r_rest   <= i_cfg.data[31:0];
                CFG_BACK_TIME:  r_back   <= i_cfg.data[31:0];
                CFG_MOVE_RECIP: r_mrecip <= i_cfg.data;
                CFG_BACK_RECIP: r_brecip <= i_cfg.data;
                CFG_MODE:       r_mode   <= i_cfg.data[0];
                default: ;      // unknown index: dropped
            endcase
        end
    end

    // user keeps config static with items in flight, unchecked; it is read directly
    logic [TW-1:0] t0;
    logic          amp_neg;
    logic [31:0]   amp_mag;

    assign t0      = r_start[TW-1:0];
    assign amp_neg = r_amp[31];
    assign amp_mag = amp_neg ? (32'd0 - r_amp) : r_amp;

    // ---------------------------------------------------------------------
    // pipeline control: one global advance, valid bits ride with data
    // ---------------------------------------------------------------------
    logic [9:1] r_vld;
    logic       r_o_vld;
    logic       adv;

    assign adv        = !r_o_vld || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_vld   <= {r_vld[8:1], i_in.valid};
            r_o_vld <= r_vld[9];
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: mask time, end of rise, rest+back length
    // ---------------------------------------------------------------------
    logic [TW-1:0]  r1_t;
    logic [TW1-1:0] r1_t1, r1_rb;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_t  <= i_in.time_now[TW-1:0];
            r1_t1 <= TW1'(t0) + TW1'(r_move[TW-1:0]);
            r1_rb <= TW1'(r_rest[TW-1:0]) + TW1'(r_back[TW-1:0]);
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: segment bounds and phase decision (no wrap, BW bits)
    // ---------------------------------------------------------------------
    logic [BW-1:0] n2_t2, n2_t3, n2_tx;
    t_phase        n2_ph;
    logic [TW-1:0] r2_t;
    logic [BW-1:0] r2_t3;
    t_phase        r2_ph;

    always_comb begin
        n2_t2 = BW'(r1_t1) + BW'(r_rest[TW-1:0]);
        n2_t3 = BW'(r1_t1) + BW'(r1_rb);
        n2_tx = BW'(r1_t);
        if (n2_tx < BW'(t0))
            n2_ph = PH_BEFORE;
        else if (n2_tx < BW'(r1_t1))
            n2_ph = PH_RISE;
        else if (!r_mode || n2_tx < n2_t2)
            n2_ph = PH_HOLD;
        else if (n2_tx < n2_t3)
            n2_ph = PH_FALL;
        else
            n2_ph = PH_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_t  <= r1_t;
            r2_t3 <= n2_t3;
            r2_ph <= n2_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: ticks into the segment (rise) or left in it (fall)
    // ---------------------------------------------------------------------
    logic [TW-1:0]      r3_dt;
    logic [RECIP_W-1:0] r3_recip;
    t_phase             r3_ph;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_dt    <= (r2_ph == PH_RISE) ? (r2_t - t0) : TW'(r2_t3 - BW'(r2_t));
            r3_recip <= (r2_ph == PH_RISE) ? r_mrecip : r_brecip;
            r3_ph    <= r2_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 4: s = min(dt*recip >> 32, 2^32-1)
    // ---------------------------------------------------------------------
    logic [64:0] n4_prod;
    logic [31:0] r4_s;
    t_phase      r4_ph;

    assign n4_prod = 65'(32'(r3_dt)) * 65'(r3_recip);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_s  <= n4_prod[64] ? 32'hffff_ffff : n4_prod[63:32];
            r4_ph <= r3_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 5: s^2 and s(1-s)
    // ---------------------------------------------------------------------
    logic [63:0]        n5_sq;
    logic [RECIP_W-1:0] n5_cm;
    logic [64:0]        n5_su;
    logic [31:0]        r5_s, r5_s2, r5_su;
    t_phase             r5_ph;

    assign n5_sq = 64'(r4_s) * 64'(r4_s);
    assign n5_cm = ONE_Q32 - RECIP_W'(r4_s);
    assign n5_su = 65'(r4_s) * 65'(n5_cm);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_s  <= r4_s;
            r5_s2 <= n5_sq[63:32];
            r5_su <= n5_su[63:32];
            r5_ph <= r4_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 6: s^3, polynomial 10 - 15s + 6s^2, (s(1-s))^2
    // ---------------------------------------------------------------------
    logic [63:0]        n6_s3, n6_usq;
    logic [31:0]        r6_s3, r6_usq;
    logic [INNER_W-1:0] r6_inner;
    t_phase             r6_ph;

    assign n6_s3  = 64'(r5_s2) * 64'(r5_s);
    assign n6_usq = 64'(r5_su) * 64'(r5_su);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_s3    <= n6_s3[63:32];
            r6_usq   <= n6_usq[63:32];
            r6_inner <= INNER_BASE + INNER_W'(r5_s2) * INNER_W'(6)
                        - INNER_W'(r5_s) * INNER_W'(15);
            r6_ph    <= r5_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 7: position shape p (capped at 1.0), velocity shape q = 30 u^2
    // ---------------------------------------------------------------------
    logic [67:0]        n7_prod;
    logic [INNER_W-1:0] n7_hi;
    logic [RECIP_W-1:0] r7_p, r7_q;
    t_phase             r7_ph;

    assign n7_prod = 68'(r6_s3) * 68'(r6_inner);
    assign n7_hi   = n7_prod[67:32];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_p  <= (n7_hi > INNER_W'(ONE_Q32)) ? ONE_Q32 : n7_hi[32:0];
            // u^2 <= 2^28, so 30 u^2 fits 33 bits
            r7_q  <= RECIP_W'(r6_usq) * RECIP_W'(30);
            r7_ph <= r6_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 8: scale by |A| (position rounded half up)
    // ---------------------------------------------------------------------
    logic [63:0] n8_pm;
    logic [31:0] r8_pm;
    logic [63:0] r8_mq;
    t_phase      r8_ph;

    assign n8_pm = 64'(amp_mag) * 64'(r7_p) + HALF_Q32;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_pm <= n8_pm[63:32];
            r8_mq <= 64'(amp_mag) * 64'(r7_q);
            r8_ph <= r7_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 9: signed saturated position; |A|q*recip as two partial products
    // ---------------------------------------------------------------------
    logic [RECIP_W-1:0] n9_recip;
    logic [64:0]        n9_plo;
    logic [POS_W-1:0]   n9_pos;
    logic [POS_W-1:0]   r9_pos;
    logic [64:0]        r9_phi;
    logic [32:0]        r9_plo;
    t_phase             r9_ph;

    assign n9_recip = (r8_ph == PH_RISE) ? r_mrecip : r_brecip;
    assign n9_plo   = 65'(r8_mq[31:0]) * 65'(n9_recip);

    always_comb begin
        if (amp_neg)
            n9_pos = 32'd0 - ((r8_pm > NEG_MAX) ? NEG_MAX : r8_pm);
        else
            n9_pos = (r8_pm > POS_MAX) ? POS_MAX : r8_pm;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_pos <= n9_pos;
            r9_phi <= 65'(r8_mq[63:32]) * 65'(n9_recip);
            r9_plo <= n9_plo[64:32];
            r9_ph  <= r8_ph;
        end
    end

    // ---------------------------------------------------------------------
    // stage 10 (output register): velocity sum, cap, sign; phase select
    // ---------------------------------------------------------------------
    logic [65:0]        n_vsum;
    logic [VMAG_W-1:0]  n_vmag;
    logic               n_vneg;
    logic [VEL_W-1:0]   n_vel, n_o_vel;
    logic [POS_W-1:0]   n_o_pos;
    logic [POS_W-1:0]   r_o_pos;
    logic [VEL_W-1:0]   r_o_vel;
    t_phase             r_o_ph;

    always_comb begin
        n_vsum = 66'(r9_phi) + 66'(r9_plo);
        n_vmag = (n_vsum > 66'(VEL_CAP)) ? VEL_CAP : n_vsum[VMAG_W-1:0];
        // fall runs the mirrored curve: slope sign is flipped
        n_vneg = amp_neg ^ (r9_ph == PH_FALL);
        n_vel  = n_vneg ? (VEL_W'(0) - VEL_W'(n_vmag)) : VEL_W'(n_vmag);
        case (r9_ph)
            PH_RISE, PH_FALL: begin
                n_o_pos = r9_pos;
                n_o_vel = n_vel;
            end
            PH_HOLD: begin
                n_o_pos = r_amp;
                n_o_vel = '0;
            end
            default: begin
                n_o_pos = '0;
                n_o_vel = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_pos <= n_o_pos;
            r_o_vel <= n_o_vel;
            r_o_ph  <= r9_ph;
        end
    end

    assign o_out.valid    = r_o_vld;
    assign o_out.position = r_o_pos;
    assign o_out.velocity = r_o_vel;
    assign o_out.phase    = r_o_ph;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    a_mode0_no_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !r_mode) |-> (r_o_ph != PH_FALL && r_o_ph != PH_DONE))
        else $error("fall or done phase reported in move-and-hold mode");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_o_ph == PH_BEFORE || r_o_ph == PH_DONE))
            |-> (o_out.position == '0 && o_out.velocity == '0))
        else $error("nonzero output outside the moving segments");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_o_ph == PH_HOLD)
            |-> (o_out.position == r_amp && o_out.velocity == '0))
        else $error("hold phase does not sit at amplitude");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input blocked without output back-pressure");

endmodule
